// ===== rtl/bbd_pkg.sv =====
// Shared constants, types and helpers for the bilinear Bayer demosaic core.
// Used by bayer_bilinear_demosaic_core and its bound checker.
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int PIX_W      = 10;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int CNT_W      = 14;
  localparam int SUM_W      = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

  // Reciprocal of three in 13 fractional bits, exact for sums below 8192.
  localparam logic [SUM_W-1:0] RECIP3 = 12'd2731;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Even size clamped to [2, max].
  function automatic logic [CNT_W-1:0] eff_size(logic [SIZE_W-1:0] v,
                                                logic [CNT_W-1:0] mx);
    logic [CNT_W-1:0] m;
    logic [CNT_W-1:0] t;
    m = mx & ~CNT_W'(1);
    t = {1'b0, v[SIZE_W-1:1], 1'b0};
    if (t < CNT_W'(2)) t = CNT_W'(2);
    if (t > m) t = m;
    return t;
  endfunction

  function automatic pix_t div3(logic [SUM_W-1:0] x);
    logic [2*SUM_W-1:0] p;
    p = x * RECIP3;
    return p[13 +: PIX_W];
  endfunction

endpackage

// ===== rtl/bayer_bilinear_demosaic_core.sv =====
// Bilinear demosaic of a BGGR Bayer stream: line stores, 3x3 window, color stage.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
//
// Raw samples enter on the s_axis channel in raster order, one item per
// accepted transfer; tuser marks the first pixel of a frame. Full-color
// pixels leave on m_axis with their row and column; tlast marks the last
// pixel of the frame. Frame width and height are written on the cfg port
// (index 0 width, index 1 height) while the block is idle; cfg_ready_o is
// always high.
// Output pixel (r,c) is produced when input (r+1,c+1) arrives, so the
// stream runs one row and one column behind; right-column pixels and the
// whole last row leave together with the input item that completes them.
// Each item passes the input stage, window stage and output register.
// An item with one result or none is taken every cycle while m_axis is
// ready; one with more results holds the input until all have left, since
// the color stage delivers one result per cycle when the output is free.
// Reset clears the position counters, the window and all valid flags; the
// line stores hold nothing until written. When m_axis stalls, the result
// waits in the output register, one more item waits in each of the window
// and input stages, and then s_axis_tready drops.

module bayer_bilinear_demosaic_core #(
  parameter int MaxWidth  = bbd_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = bbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] raw_pixel, [15:10] zero
  input  logic [bbd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] frame_start
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [9:0] blue, [19:10] green, [29:20] red, [41:30] pixel_row,
  // [53:42] pixel_column, [55:54] zero
  output logic [bbd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [bbd_pkg::SIZE_W-1:0]      cfg_data_i
);

  localparam int AW = $clog2(MaxWidth);
  localparam int CW = bbd_pkg::CNT_W;
  localparam int PW = bbd_pkg::PIX_W;
  localparam int SW = bbd_pkg::SUM_W;
  localparam logic [CW-1:0] MaxW = CW'(MaxWidth);
  localparam logic [CW-1:0] MaxH = CW'(MaxHeight);

  // configuration
  logic [bbd_pkg::SIZE_W-1:0] width_cfg_q, height_cfg_q;
  logic [CW-1:0] w_eff, h_eff;

  assign cfg_ready_o = 1'b1;
  assign w_eff = bbd_pkg::eff_size(width_cfg_q, MaxW);
  assign h_eff = bbd_pkg::eff_size(height_cfg_q, MaxH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= bbd_pkg::WIDTH_RESET;
      height_cfg_q <= bbd_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (bbd_pkg::cfg_reg_e'(cfg_index_i))
        bbd_pkg::REG_FRAME_WIDTH:  width_cfg_q  <= cfg_data_i;
        bbd_pkg::REG_FRAME_HEIGHT: height_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input position
  logic [CW-1:0] col_cnt_q, row_cnt_q, col_cnt_d, row_cnt_d;
  logic [CW-1:0] in_col, in_row;
  logic          in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_col = s_axis_tuser ? '0 : col_cnt_q;
    in_row = s_axis_tuser ? '0 : row_cnt_q;
    if (in_col >= w_eff) begin
      in_col = '0;
      in_row = in_row + CW'(1);
    end
    if (in_row >= h_eff) in_row = '0;
    col_cnt_d = in_col + CW'(1);
    row_cnt_d = in_row;
    if (col_cnt_d >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = in_row + CW'(1);
      if (row_cnt_d >= h_eff) row_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // input stage
  logic          a_valid_q;
  bbd_pkg::pix_t a_pix_q;
  logic [CW-1:0] a_col_q, a_row_q, a_w_q, a_h_q;
  logic          a_adv;

  // line stores
  bbd_pkg::pix_t older_mem [MaxWidth];
  bbd_pkg::pix_t newer_mem [MaxWidth];
  bbd_pkg::pix_t older_rd_q, newer_rd_q;
  logic [AW-1:0] rd_addr, a_addr;

  assign rd_addr = in_col[AW-1:0];
  assign a_addr  = a_col_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      newer_rd_q <= newer_mem[rd_addr];
      newer_mem[rd_addr] <= s_axis_tdata[PW-1:0];
      // The older store is written when the item leaves the input stage; forward that write.
      if (a_adv && (a_addr == rd_addr)) begin
        older_rd_q <= newer_rd_q;
      end else begin
        older_rd_q <= older_mem[rd_addr];
      end
    end
    if (a_adv) begin
      older_mem[a_addr] <= newer_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q <= s_axis_tdata[PW-1:0];
      a_col_q <= in_col;
      a_row_q <= in_row;
      a_w_q   <= w_eff;
      a_h_q   <= h_eff;
    end
  end

  // Results owed by the item in the input stage, in delivery order.
  logic [3:0] a_mask;
  always_comb begin
    a_mask[0] = (a_row_q != '0) && (a_col_q != '0);
    a_mask[1] = (a_row_q != '0) && (a_col_q == a_w_q - CW'(1));
    a_mask[2] = (a_row_q == a_h_q - CW'(1)) && (a_col_q != '0);
    a_mask[3] = (a_row_q == a_h_q - CW'(1)) && (a_col_q == a_w_q - CW'(1));
  end

  // window stage
  bbd_pkg::pix_t win_q [3][3];
  logic [3:0]    b_mask_q, b_mask_d;
  logic [CW-1:0] b_col_q, b_row_q, b_w_q, b_h_q;
  logic [3:0]    sel;
  logic          out_free, emit;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign sel      = b_mask_q & (~b_mask_q + 4'd1);
  assign emit     = (b_mask_q != '0) && out_free;
  assign b_mask_d = emit ? (b_mask_q & ~sel) : b_mask_q;
  assign a_adv    = a_valid_q && (b_mask_d == '0);
  assign s_axis_tready = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_mask_q <= '0;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          win_q[y][x] <= '0;
        end
      end
    end else if (a_adv) begin
      b_mask_q <= a_mask;
      for (int y = 0; y < 3; y++) begin
        win_q[y][0] <= win_q[y][1];
        win_q[y][1] <= win_q[y][2];
      end
      win_q[0][2] <= older_rd_q;
      win_q[1][2] <= newer_rd_q;
      win_q[2][2] <= a_pix_q;
    end else begin
      b_mask_q <= b_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_col_q <= a_col_q;
      b_row_q <= a_row_q;
      b_w_q   <= a_w_q;
      b_h_q   <= a_h_q;
    end
  end

  // color stage
  logic          ro, co;
  logic [CW-1:0] er_row, er_col;
  logic [SW-1:0] n [3][3];
  bbd_pkg::pix_t blue_c, green_c, red_c;
  logic          last_c;

  always_comb begin
    ro = sel[2] || sel[3];
    co = sel[1] || sel[3];
    er_row = ro ? b_row_q : b_row_q - CW'(1);
    er_col = co ? b_w_q - CW'(1) : b_col_q - CW'(1);
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        n[y][x] = '0;
      end
    end
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        if ((y + int'(ro) <= 2) && (x + int'(co) <= 2)) begin
          n[y][x] = SW'(win_q[y + int'(ro)][x + int'(co)]);
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] ul, up, ur, lf, ct, rt, dl, dn, dr, s4, t;
    logic top, bot, lft, rgt;
    ul = n[0][0]; up = n[0][1]; ur = n[0][2];
    lf = n[1][0]; ct = n[1][1]; rt = n[1][2];
    dl = n[2][0]; dn = n[2][1]; dr = n[2][2];
    t = '0;
    top = (er_row == '0);
    bot = (er_row == b_h_q - CW'(1));
    lft = (er_col == '0);
    rgt = (er_col == b_w_q - CW'(1));
    last_c = bot && rgt;
    blue_c = ct[PW-1:0];
    green_c = ct[PW-1:0];
    red_c = ct[PW-1:0];
    s4 = ul + ur + dl + dr;
    if (!er_row[0] && !er_col[0]) begin
      // blue site
      if (top && lft) begin
        t = dn + rt;
        green_c = t[PW:1];
      end else if (top) begin
        green_c = bbd_pkg::div3(lf + dn + rt);
      end else if (lft) begin
        green_c = bbd_pkg::div3(up + rt + dn);
      end else begin
        t = lf + rt + up + dn;
        green_c = t[PW+1:2];
      end
      if (!top && !lft) begin
        red_c = s4[PW+1:2];
      end else if (top && !lft) begin
        t = dl + dr;
        red_c = t[PW:1];
      end else if (!top && lft) begin
        t = ur + dr;
        red_c = t[PW:1];
      end else begin
        red_c = dr[PW-1:0];
      end
    end else if (!er_row[0]) begin
      // green on a blue row
      t = lf + rt;
      blue_c = rgt ? lf[PW-1:0] : t[PW:1];
      t = up + dn;
      red_c = top ? dn[PW-1:0] : t[PW:1];
    end else if (!er_col[0]) begin
      // green on a red row
      t = up + dn;
      blue_c = bot ? up[PW-1:0] : t[PW:1];
      t = lf + rt;
      red_c = lft ? rt[PW-1:0] : t[PW:1];
    end else begin
      // red site
      if (!rgt && !bot) begin
        blue_c = s4[PW+1:2];
      end else if (bot && !rgt) begin
        t = ul + ur;
        blue_c = t[PW:1];
      end else if (!bot && rgt) begin
        t = ul + dl;
        blue_c = t[PW:1];
      end else begin
        blue_c = ul[PW-1:0];
      end
      if (bot && !rgt) begin
        green_c = bbd_pkg::div3(lf + up + rt);
      end else if (!bot && rgt) begin
        green_c = bbd_pkg::div3(up + lf + dn);
      end else if (bot && rgt) begin
        t = up + lf;
        green_c = t[PW:1];
      end else begin
        t = lf + rt + up + dn;
        green_c = t[PW+1:2];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_axis_tdata <= {2'b00, er_col[bbd_pkg::POS_W-1:0], er_row[bbd_pkg::POS_W-1:0],
                       red_c, green_c, blue_c};
      m_axis_tlast <= last_c;
    end
  end

endmodule

// ===== rtl/bbd_checker.sv =====
// Port-level checks for bayer_bilinear_demosaic_core, attached by bind.
// Depends on bbd_pkg.
`timescale 1ns / 1ps

module bbd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           cfg_ready_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Sizes are even, so the last pixel sits on an odd row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[30] && m_axis_tdata[42])
    else $error("frame end on even position");

  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid in reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind bayer_bilinear_demosaic_core bbd_checker u_bbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);
